// ===== src/rlma_pkg.sv =====
package rlma_pkg;

  localparam int unsigned MOD3_W = 18;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_XSUM,
    ST_YLEN,
    ST_YXS,
    ST_YY,
    ST_YYL,
    ST_N0,
    ST_N1,
    ST_N2,
    ST_M0,
    ST_M1,
    ST_M2,
    ST_MSUB,
    ST_WAIT_OUT,
    ST_DIV_GO,
    ST_DIV_WAIT
  } state_e;

  typedef enum logic [2:0] {
    DIV_COL,
    DIV_ROW,
    DIV_CC,
    DIV_CR,
    DIV_RR
  } div_sel_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Since four is one modulo three, the residue is the sum of the base-four digits.
  function automatic logic [1:0] mod3_f(input logic [MOD3_W-1:0] v);
    logic [2:0] r;
    r = '0;
    for (int i = 0; i < MOD3_W / 2; i++) begin
      r = r + {1'b0, v[2*i +: 2]};
      if (r >= 3'd3) begin
        r = r - 3'd3;
      end
    end
    return r[1:0];
  endfunction

endpackage

// ===== src/rlma_div.sv =====
module rlma_div #(
  parameter int unsigned NUM_W = 57,
  parameter int unsigned DEN_W = 25
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [NUM_W-1:0]          num_i,
  input  logic [DEN_W-1:0]          den_i,
  output rlma_pkg::div_status_t     status_o,
  output logic [NUM_W-1:0]          quo_o
);
  import rlma_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] nq_q, nq_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             ge;

  assign rem_sh  = {rem_q, nq_q[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den_i};
  assign rem_sub = rem_sh - {1'b0, den_i};

  always_comb begin
    nq_d   = nq_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i && !busy_q) begin
      nq_d   = num_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      nq_d  = {nq_q[NUM_W-2:0], ge};
      rem_d = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nq_q  <= nq_d;
    rem_q <= rem_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quo_o         = nq_q;

endmodule

// ===== src/run_length_moment_accumulator.sv =====
// A run with last_col at or above first_col keeps in_ready_o low after acceptance while
// one shared multiplier steps through the multiply sequence; no new run is taken until
// it is through. A reversed run that does not end a region leaves in_ready_o high. A run
// marked end_of_region adds the ST_WAIT_OUT state plus, for a nonempty region, five
// serial divisions; out_valid_o rises as in_ready_o returns, later if a result waits.
// Reset (rst_ni low, asynchronous) clears all sums, the sequencer and out_valid_o.
module run_length_moment_accumulator #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [COORD_BITS-1:0]            row_i,
  input  logic [COORD_BITS-1:0]            first_col_i,
  input  logic [COORD_BITS-1:0]            last_col_i,
  input  logic                             end_of_region_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [2*COORD_BITS:0]            area_o,
  output logic [COORD_BITS+FRAC_BITS-1:0]  mean_col_o,
  output logic [COORD_BITS+FRAC_BITS-1:0]  mean_row_o,
  output logic [2*COORD_BITS+FRAC_BITS-1:0] second_col_col_o,
  output logic [2*COORD_BITS+FRAC_BITS-1:0] second_col_row_o,
  output logic [2*COORD_BITS+FRAC_BITS-1:0] second_row_row_o,
  output logic                             empty_region_o
);
  import rlma_pkg::*;

  localparam int unsigned AREA_W  = 2 * COORD_BITS + 1;
  localparam int unsigned SUM1_W  = 3 * COORD_BITS + 1;
  localparam int unsigned SUM2_W  = 4 * COORD_BITS + 1;
  localparam int unsigned MEAN1_W = COORD_BITS + FRAC_BITS;
  localparam int unsigned MEAN2_W = 2 * COORD_BITS + FRAC_BITS;
  localparam int unsigned LEN_W   = COORD_BITS + 1;
  localparam int unsigned MUL_W   = 2 * COORD_BITS;
  localparam int unsigned PROD_W  = 3 * COORD_BITS + 1;
  localparam int unsigned DIVD_W  = SUM2_W + FRAC_BITS;
  localparam logic [63:0] INV3_FULL = ((64'd1 << (MUL_W + 1)) + 64'd1) / 64'd3;
  localparam logic [MUL_W-1:0] INV3 = INV3_FULL[MUL_W-1:0];

  state_e   state_q, state_d;
  div_sel_e div_sel_q, div_sel_d;

  logic [COORD_BITS-1:0] y_q, n_q, v_q;
  logic [LEN_W-1:0]      len_q, mn_q;
  logic                  n_is1_q, v_is1_q, last_q, m_zero_q;
  logic [MUL_W-1:0]      xsum_q, xsum_d, tmp_q, tmp_d;
  logic [PROD_W-1:0]     p_q, p_d;

  logic [AREA_W-1:0] area_sum_q, area_sum_d;
  logic [SUM1_W-1:0] col_sum_q, col_sum_d, row_sum_q, row_sum_d;
  logic [SUM2_W-1:0] col_sq_sum_q, col_sq_sum_d;
  logic [SUM2_W-1:0] col_row_sum_q, col_row_sum_d;
  logic [SUM2_W-1:0] row_sq_sum_q, row_sq_sum_d;

  logic                       out_valid_q, out_valid_d;
  logic [AREA_W-1:0]          area_q, area_d;
  logic [MEAN1_W-1:0]         mean_col_q, mean_col_d, mean_row_q, mean_row_d;
  logic [MEAN2_W-1:0]         scc_q, scc_d, scr_q, scr_d, srr_q, srr_d;
  logic                       empty_q, empty_d;

  logic                  accept;
  logic                  run_ok;
  logic [COORD_BITS-1:0] m_dec;
  logic [LEN_W-1:0]      len_in, mn_in;
  logic [MUL_W-1:0]      mul_a, mul_b;
  logic [2*MUL_W-1:0]    mul_full;
  logic [COORD_BITS-1:0] pv;
  logic                  p_is1;
  logic [MUL_W-1:0]      half_p;
  logic                  div_start;
  logic [DIVD_W-1:0]     div_num;
  logic [DIVD_W-1:0]     div_quo;
  div_status_t           div_status;
  logic                  sat1, sat2;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign run_ok     = last_col_i >= first_col_i;
  assign m_dec      = first_col_i - {{(COORD_BITS-1){1'b0}}, 1'b1};
  assign len_in     = {1'b0, last_col_i} - {1'b0, first_col_i} + {{COORD_BITS{1'b0}}, 1'b1};
  assign mn_in      = {1'b0, last_col_i} + {1'b0, first_col_i};

  assign pv     = (state_q == ST_N1) ? n_q : v_q;
  assign p_is1  = (state_q == ST_N1) ? n_is1_q : v_is1_q;
  assign half_p = p_q[MUL_W:1];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_XSUM: begin
        mul_a = MUL_W'(mn_q);
        mul_b = MUL_W'(len_q);
      end
      ST_YLEN: begin
        mul_a = MUL_W'(y_q);
        mul_b = MUL_W'(len_q);
      end
      ST_YXS: begin
        mul_a = MUL_W'(y_q);
        mul_b = xsum_q;
      end
      ST_YY: begin
        mul_a = MUL_W'(y_q);
        mul_b = MUL_W'(y_q);
      end
      ST_YYL: begin
        mul_a = p_q[MUL_W-1:0];
        mul_b = MUL_W'(len_q);
      end
      ST_N0: begin
        mul_a = MUL_W'(n_q);
        mul_b = MUL_W'({1'b0, n_q} + {{COORD_BITS{1'b0}}, 1'b1});
      end
      ST_M0: begin
        mul_a = MUL_W'(v_q);
        mul_b = MUL_W'({1'b0, v_q} + {{COORD_BITS{1'b0}}, 1'b1});
      end
      ST_N1, ST_M1: begin
        mul_a = p_is1 ? MUL_W'({pv, 1'b1}) : half_p;
        mul_b = INV3;
      end
      ST_N2, ST_M2: begin
        mul_a = p_q[MUL_W-1:0];
        mul_b = tmp_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;
  assign p_d      = mul_full[PROD_W-1:0];

  always_comb begin
    unique case (div_sel_q)
      DIV_COL: div_num = DIVD_W'(col_sum_q) << FRAC_BITS;
      DIV_ROW: div_num = DIVD_W'(row_sum_q) << FRAC_BITS;
      DIV_CC:  div_num = DIVD_W'(col_sq_sum_q) << FRAC_BITS;
      DIV_CR:  div_num = DIVD_W'(col_row_sum_q) << FRAC_BITS;
      DIV_RR:  div_num = DIVD_W'(row_sq_sum_q) << FRAC_BITS;
      default: div_num = '0;
    endcase
  end

  assign sat1 = |div_quo[DIVD_W-1:MEAN1_W];
  assign sat2 = |div_quo[DIVD_W-1:MEAN2_W];

  rlma_div #(
    .NUM_W (DIVD_W),
    .DEN_W (AREA_W)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (div_num),
    .den_i    (area_sum_q),
    .status_o (div_status),
    .quo_o    (div_quo)
  );

  always_comb begin
    state_d       = state_q;
    div_sel_d     = div_sel_q;
    xsum_d        = xsum_q;
    tmp_d         = tmp_q;
    area_sum_d    = area_sum_q;
    col_sum_d     = col_sum_q;
    row_sum_d     = row_sum_q;
    col_sq_sum_d  = col_sq_sum_q;
    col_row_sum_d = col_row_sum_q;
    row_sq_sum_d  = row_sq_sum_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    area_d        = area_q;
    mean_col_d    = mean_col_q;
    mean_row_d    = mean_row_q;
    scc_d         = scc_q;
    scr_d         = scr_q;
    srr_d         = srr_q;
    empty_d       = empty_q;
    div_start     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (run_ok) begin
            state_d = ST_XSUM;
          end else if (end_of_region_i) begin
            state_d = ST_WAIT_OUT;
          end
        end
      end
      ST_XSUM: begin
        area_sum_d = area_sum_q + AREA_W'(len_q);
        state_d    = ST_YLEN;
      end
      ST_YLEN: begin
        xsum_d    = half_p;
        col_sum_d = col_sum_q + SUM1_W'(p_q[PROD_W-1:1]);
        state_d   = ST_YXS;
      end
      ST_YXS: begin
        row_sum_d = row_sum_q + p_q;
        state_d   = ST_YY;
      end
      ST_YY: begin
        col_row_sum_d = col_row_sum_q + SUM2_W'(p_q);
        state_d       = ST_YYL;
      end
      ST_YYL: begin
        state_d = ST_N0;
      end
      ST_N0: begin
        row_sq_sum_d = row_sq_sum_q + SUM2_W'(p_q);
        state_d      = ST_N1;
      end
      ST_N1: begin
        tmp_d   = p_is1 ? half_p : MUL_W'({pv, 1'b1});
        state_d = ST_N2;
      end
      ST_N2: begin
        state_d = ST_M0;
      end
      ST_M0: begin
        col_sq_sum_d = col_sq_sum_q + SUM2_W'(p_q);
        state_d      = ST_M1;
      end
      ST_M1: begin
        tmp_d   = p_is1 ? half_p : MUL_W'({pv, 1'b1});
        state_d = ST_M2;
      end
      ST_M2: begin
        state_d = ST_MSUB;
      end
      ST_MSUB: begin
        if (!m_zero_q) begin
          col_sq_sum_d = col_sq_sum_q - SUM2_W'(p_q);
        end
        state_d = last_q ? ST_WAIT_OUT : ST_IDLE;
      end
      ST_WAIT_OUT: begin
        if (!out_valid_q) begin
          if (area_sum_q == '0) begin
            area_d        = '0;
            mean_col_d    = '0;
            mean_row_d    = '0;
            scc_d         = '0;
            scr_d         = '0;
            srr_d         = '0;
            empty_d       = 1'b1;
            out_valid_d   = 1'b1;
            col_sum_d     = '0;
            row_sum_d     = '0;
            col_sq_sum_d  = '0;
            col_row_sum_d = '0;
            row_sq_sum_d  = '0;
            state_d       = ST_IDLE;
          end else begin
            div_sel_d = DIV_COL;
            state_d   = ST_DIV_GO;
          end
        end
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_status.done) begin
          state_d = ST_DIV_GO;
          unique case (div_sel_q)
            DIV_COL: begin
              mean_col_d = sat1 ? '1 : div_quo[MEAN1_W-1:0];
              div_sel_d  = DIV_ROW;
            end
            DIV_ROW: begin
              mean_row_d = sat1 ? '1 : div_quo[MEAN1_W-1:0];
              div_sel_d  = DIV_CC;
            end
            DIV_CC: begin
              scc_d     = sat2 ? '1 : div_quo[MEAN2_W-1:0];
              div_sel_d = DIV_CR;
            end
            DIV_CR: begin
              scr_d     = sat2 ? '1 : div_quo[MEAN2_W-1:0];
              div_sel_d = DIV_RR;
            end
            DIV_RR: begin
              srr_d         = sat2 ? '1 : div_quo[MEAN2_W-1:0];
              area_d        = area_sum_q;
              empty_d       = 1'b0;
              out_valid_d   = 1'b1;
              area_sum_d    = '0;
              col_sum_d     = '0;
              row_sum_d     = '0;
              col_sq_sum_d  = '0;
              col_row_sum_d = '0;
              row_sq_sum_d  = '0;
              state_d       = ST_IDLE;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      div_sel_q     <= DIV_COL;
      out_valid_q   <= 1'b0;
      area_sum_q    <= '0;
      col_sum_q     <= '0;
      row_sum_q     <= '0;
      col_sq_sum_q  <= '0;
      col_row_sum_q <= '0;
      row_sq_sum_q  <= '0;
    end else begin
      state_q       <= state_d;
      div_sel_q     <= div_sel_d;
      out_valid_q   <= out_valid_d;
      area_sum_q    <= area_sum_d;
      col_sum_q     <= col_sum_d;
      row_sum_q     <= row_sum_d;
      col_sq_sum_q  <= col_sq_sum_d;
      col_row_sum_q <= col_row_sum_d;
      row_sq_sum_q  <= row_sq_sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      y_q      <= row_i;
      n_q      <= last_col_i;
      v_q      <= m_dec;
      len_q    <= len_in;
      mn_q     <= mn_in;
      last_q   <= end_of_region_i;
      m_zero_q <= (first_col_i == '0);
      n_is1_q  <= mod3_f(MOD3_W'(last_col_i)) == 2'd1;
      v_is1_q  <= mod3_f(MOD3_W'(m_dec)) == 2'd1;
    end
    p_q        <= p_d;
    xsum_q     <= xsum_d;
    tmp_q      <= tmp_d;
    area_q     <= area_d;
    mean_col_q <= mean_col_d;
    mean_row_q <= mean_row_d;
    scc_q      <= scc_d;
    scr_q      <= scr_d;
    srr_q      <= srr_d;
    empty_q    <= empty_d;
  end

  assign out_valid_o      = out_valid_q;
  assign area_o           = area_q;
  assign mean_col_o       = mean_col_q;
  assign mean_row_o       = mean_row_q;
  assign second_col_col_o = scc_q;
  assign second_col_row_o = scr_q;
  assign second_row_row_o = srr_q;
  assign empty_region_o   = empty_q;

  a_idle_div_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_status.busy)
    else $error("Divider busy while the block accepts runs.");

  a_empty_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (empty_region_o == (area_o == '0)))
    else $error("Empty region flag disagrees with the area.");

  a_div_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV_GO) |-> !div_status.busy)
    else $error("Division started while the divider is busy.");

  a_post_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_WAIT_OUT || $past(state_q) == ST_DIV_WAIT))
    else $error("Result posted outside the region end sequence.");

endmodule
